@@ hw/rtl/ptd_pkg.sv @@
`default_nettype none

package ptd_pkg;

    // Request kinds carried on s_tuser
    localparam logic [2:0] REQ_TICK    = 3'd0;
    localparam logic [2:0] REQ_CREATE  = 3'd1;
    localparam logic [2:0] REQ_SUSPEND = 3'd2;
    localparam logic [2:0] REQ_RESUME  = 3'd3;
    localparam logic [2:0] REQ_DELETE  = 3'd4;

    localparam int TASK_COUNT_DEF = 8;

    localparam int REQ_W    = 3;
    localparam int INDEX_W  = 3;
    localparam int PERIOD_W = 16;
    localparam int DUE_W    = 3;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;
    localparam int DIV_CNT_W = 4;

    typedef struct packed {
        logic apply_req;
        logic tick_start;
        logic slot_next;
        logic div_start;
        logic div_step;
        logic emit_load;
    } ptd_cmd_t;

    typedef struct packed {
        logic req_is_tick;
        logic slot_eligible;
        logic slot_last;
        logic div_last;
        logic mask_empty;
        logic mask_single;
        logic out_free;
    } ptd_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptd_ctrl.sv @@
`default_nettype none

module ptd_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire ptd_pkg::ptd_status_t status,
    output ptd_pkg::ptd_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (status.req_is_tick) begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_SCAN;
                    end else begin
                        cmd.apply_req = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                // wait for the registered period read
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (status.slot_eligible) begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end else if (status.slot_last) begin
                    state_next = S_EMIT;
                end else begin
                    cmd.slot_next = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    if (status.slot_last) begin
                        state_next = S_EMIT;
                    end else begin
                        cmd.slot_next = 1'b1;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_EMIT: begin
                if (status.mask_empty) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.mask_single) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> status.out_free)
        else $error("result loaded while output word still waits");

    a_div_runs_to_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) && !status.div_last |=> (state_reg == S_DIV))
        else $error("remainder run left early");

endmodule

`default_nettype wire

@@ hw/rtl/ptd_datapath.sv @@
`default_nettype none

module ptd_datapath #(
    parameter int TASK_COUNT = ptd_pkg::TASK_COUNT_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [ptd_pkg::REQ_W-1:0]     s_tuser,
    input  wire logic [ptd_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [ptd_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    input  wire ptd_pkg::ptd_cmd_t             cmd,
    output ptd_pkg::ptd_status_t               status
);

    localparam int SLOT_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
    localparam int PW     = ptd_pkg::PERIOD_W;
    localparam int CW     = ptd_pkg::DIV_CNT_W;

    // Slot table
    logic [PW-1:0]         period_mem [TASK_COUNT];
    logic [TASK_COUNT-1:0] occupied_reg;
    logic [TASK_COUNT-1:0] suspended_reg;
    logic [PW-1:0]         per_rd_reg;

    logic [PW-1:0]         tick_reg;
    logic [SLOT_W-1:0]     ptr_reg;
    logic [TASK_COUNT-1:0] mask_reg;

    // Serial remainder unit
    logic [PW-1:0] rem_reg;
    logic [PW-1:0] dvd_reg;
    logic [PW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW:0]   trial;
    logic [PW-1:0] rem_next;

    logic                           out_valid_reg;
    logic [ptd_pkg::DUE_W-1:0]      out_task_reg;
    logic                           out_last_reg;

    logic [ptd_pkg::INDEX_W-1:0]    req_index;
    logic [PW-1:0]                  req_period;
    logic                           index_ok;
    logic [SLOT_W-1:0]              req_slot;

    logic [TASK_COUNT-1:0] mask_low;
    logic [TASK_COUNT-1:0] mask_rest;
    logic [SLOT_W-1:0]     low_index;

    assign req_index  = s_tdata[ptd_pkg::INDEX_W-1:0];
    assign req_period = s_tdata[ptd_pkg::INDEX_W +: PW];
    assign index_ok   = 32'(req_index) < TASK_COUNT;
    assign req_slot   = SLOT_W'(req_index);

    always_ff @(posedge aclk) begin
        if (cmd.apply_req && index_ok && (s_tuser == ptd_pkg::REQ_CREATE)
                && !occupied_reg[req_slot]) begin
            period_mem[req_slot] <= req_period;
        end
        per_rd_reg <= period_mem[ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupied_reg  <= '0;
            suspended_reg <= '0;
        end else if (cmd.apply_req && index_ok) begin
            case (s_tuser)
                ptd_pkg::REQ_CREATE: begin
                    if (!occupied_reg[req_slot]) begin
                        occupied_reg[req_slot]  <= 1'b1;
                        suspended_reg[req_slot] <= 1'b0;
                    end
                end
                ptd_pkg::REQ_SUSPEND: suspended_reg[req_slot] <= 1'b1;
                ptd_pkg::REQ_RESUME:  suspended_reg[req_slot] <= 1'b0;
                ptd_pkg::REQ_DELETE:  occupied_reg[req_slot]  <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
        end else if (cmd.tick_start) begin
            tick_reg <= tick_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_start) begin
            ptr_reg <= '0;
        end else if (cmd.slot_next) begin
            ptr_reg <= ptr_reg + 1'b1;
        end
    end

    // Restoring remainder, one dividend bit per cycle
    assign trial    = {rem_reg, dvd_reg[PW-1]};
    assign rem_next = (trial >= {1'b0, dvs_reg}) ? PW'(trial - {1'b0, dvs_reg})
                                                 : trial[PW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            rem_reg <= '0;
            dvd_reg <= tick_reg;
            dvs_reg <= per_rd_reg;
            cnt_reg <= CW'(PW - 1);
        end else if (cmd.div_step) begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[PW-2:0], 1'b0};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Due set: lowest slot goes out first
    assign mask_low  = mask_reg & (~mask_reg + 1'b1);
    assign mask_rest = mask_reg & (mask_reg - 1'b1);

    always_comb begin
        low_index = '0;
        for (int i = 0; i < TASK_COUNT; i++) begin
            if (mask_low[i]) begin
                low_index = low_index | SLOT_W'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_start) begin
            mask_reg <= '0;
        end else if (cmd.div_step && (cnt_reg == '0) && (rem_next == '0)) begin
            mask_reg[ptr_reg] <= 1'b1;
        end else if (cmd.emit_load) begin
            mask_reg <= mask_rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_task_reg <= ptd_pkg::DUE_W'(low_index);
            out_last_reg <= (mask_rest == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ptd_pkg::M_DATA_W'(out_task_reg);
    assign m_tlast  = out_last_reg;

    assign status.req_is_tick   = (s_tuser == ptd_pkg::REQ_TICK);
    assign status.slot_eligible = occupied_reg[ptr_reg] && !suspended_reg[ptr_reg]
                                  && (per_rd_reg != '0);
    assign status.slot_last     = (32'(ptr_reg) == TASK_COUNT - 1);
    assign status.div_last      = (cnt_reg == '0);
    assign status.mask_empty    = (mask_reg == '0);
    assign status.mask_single   = (mask_rest == '0);
    assign status.out_free      = !out_valid_reg || m_tready;

    a_mask_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tick_start |=> (mask_reg == '0))
        else $error("due set not cleared at tick start");

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_load |-> (mask_reg != '0))
        else $error("result loaded from an empty due set");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |=> (rem_reg < dvs_reg))
        else $error("partial remainder not below period");

endmodule

`default_nettype wire

@@ hw/rtl/periodic_task_dispatcher_core.sv @@
`default_nettype none

// Channel   Dir  Ports                     Contents
// s_        in   tvalid/tready/tuser/tdata  request kind; slot index and period
// m_        out  tvalid/tready/tdata/tlast  due slot index; last due slot of a tick
//
// Create, suspend, resume and delete words are applied in the cycle they are accepted.
// A tick word is accepted, then every slot is scanned with a period read and a check;
// each occupied, running slot with a nonzero period runs a remainder (one remainder bit
// per cycle), and then the due results are listed, one per output word.
// The serial remainder unit and the single read port of the period table set this pace.
// Reset (aresetn low, synchronous) frees every slot, clears suspend marks and
// zeroes the tick counter. A stalled m_ side holds the output word and pauses
// the result drain; the next word on s_ is taken once the tick is fully listed.
module periodic_task_dispatcher_core #(
    parameter int TASK_COUNT = ptd_pkg::TASK_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    input  wire logic [23:0] s_tdata,   // task_index[2:0], period[18:3], zero[23:19]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // due_task[2:0], zero[7:3]
    output logic             m_tlast
);

    ptd_pkg::ptd_cmd_t    cmd;
    ptd_pkg::ptd_status_t status;

    // Sequence scan, remainder runs and result drain
    ptd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Hold slot table, tick counter, remainder unit and output word
    ptd_datapath #(
        .TASK_COUNT (TASK_COUNT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;

    localparam int TASKS       = ptd_pkg::TASK_COUNT_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE      = 200;
    localparam int RAND_WORDS  = 40;   // per idling phase, four phases

    // request codes the block must ignore
    localparam logic [2:0] REQ_BAD_5 = 3'd5;
    localparam logic [2:0] REQ_BAD_6 = 3'd6;
    localparam logic [2:0] REQ_BAD_7 = 3'd7;

    typedef struct packed {
        logic [2:0] slot;
        logic       last;
    } due_t;

    // one directed word; due_mask is used only where typed is set
    typedef struct packed {
        logic [2:0]  req;
        logic [2:0]  idx;
        logic [15:0] per;
        logic        typed;
        logic [7:0]  due_mask;
    } plan_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser  = '0;
    logic [23:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // scheduler mirror
    logic [15:0] tick_total;
    logic [15:0] slot_per [TASKS];
    logic [7:0]  slot_busy;
    logic [7:0]  slot_held;

    due_t due_fifo [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int quiet_cycles   = 0;
    int fail_count     = 0;
    int words_sent     = 0;
    int ticks_sent     = 0;
    int dues_checked   = 0;
    int widest_tick    = 0;

    plan_row_t directed_plan [25] = '{
        '{ptd_pkg::REQ_TICK,    3'd0, 16'd0,     1'b1, 8'h00},  // empty table after reset
        '{ptd_pkg::REQ_CREATE,  3'd0, 16'd1,     1'b0, 8'h00},
        '{ptd_pkg::REQ_CREATE,  3'd7, 16'hFFFF,  1'b0, 8'h00},
        '{ptd_pkg::REQ_CREATE,  3'd3, 16'd0,     1'b0, 8'h00},  // zero period, never due
        '{ptd_pkg::REQ_CREATE,  3'd0, 16'd5,     1'b0, 8'h00},  // occupied, dropped
        '{ptd_pkg::REQ_TICK,    3'd5, 16'hFFFF,  1'b1, 8'h01},
        '{ptd_pkg::REQ_SUSPEND, 3'd0, 16'd0,     1'b0, 8'h00},
        '{ptd_pkg::REQ_TICK,    3'd0, 16'd0,     1'b1, 8'h00},
        '{ptd_pkg::REQ_RESUME,  3'd0, 16'd0,     1'b0, 8'h00},
        '{ptd_pkg::REQ_CREATE,  3'd2, 16'd2,     1'b0, 8'h00},
        '{ptd_pkg::REQ_TICK,    3'd7, 16'd0,     1'b1, 8'h05},
        '{ptd_pkg::REQ_SUSPEND, 3'd5, 16'd0,     1'b0, 8'h00},  // free slot
        '{ptd_pkg::REQ_CREATE,  3'd5, 16'd1,     1'b0, 8'h00},  // clears the suspend mark
        '{ptd_pkg::REQ_DELETE,  3'd2, 16'd0,     1'b0, 8'h00},
        '{ptd_pkg::REQ_TICK,    3'd0, 16'd0,     1'b1, 8'h21},
        '{ptd_pkg::REQ_DELETE,  3'd6, 16'd0,     1'b0, 8'h00},  // free slot
        '{REQ_BAD_5,            3'd1, 16'd7,     1'b0, 8'h00},
        '{REQ_BAD_6,            3'd4, 16'd7,     1'b0, 8'h00},
        '{REQ_BAD_7,            3'd6, 16'd7,     1'b0, 8'h00},
        '{ptd_pkg::REQ_CREATE,  3'd2, 16'd3,     1'b0, 8'h00},
        '{ptd_pkg::REQ_CREATE,  3'd1, 16'd1,     1'b0, 8'h00},
        '{ptd_pkg::REQ_CREATE,  3'd4, 16'd1,     1'b0, 8'h00},
        '{ptd_pkg::REQ_CREATE,  3'd6, 16'd1,     1'b0, 8'h00},
        '{ptd_pkg::REQ_TICK,    3'd3, 16'h5A5A,  1'b1, 8'h77},
        '{ptd_pkg::REQ_RESUME,  3'd1, 16'd0,     1'b0, 8'h00}
    };

    periodic_task_dispatcher_core #(
        .TASK_COUNT(TASKS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // update the mirror for one accepted word, return the mask of due slots
    task automatic apply_request(input logic [2:0] req, input logic [2:0] idx,
                                 input logic [15:0] per, output logic [7:0] due);
        due = '0;
        case (req)
            ptd_pkg::REQ_TICK: begin
                tick_total = tick_total + 16'd1;
                for (int k = 0; k < TASKS; k++)
                    if (slot_busy[k] && !slot_held[k] && slot_per[k] != 16'd0 &&
                        tick_total % slot_per[k] == 16'd0)
                        due[k] = 1'b1;
            end
            ptd_pkg::REQ_CREATE: begin
                if (!slot_busy[idx]) begin
                    slot_per[idx]  = per;
                    slot_held[idx] = 1'b0;
                    slot_busy[idx] = 1'b1;
                end
            end
            ptd_pkg::REQ_SUSPEND: slot_held[idx] = 1'b1;
            ptd_pkg::REQ_RESUME:  slot_held[idx] = 1'b0;
            ptd_pkg::REQ_DELETE:  slot_busy[idx] = 1'b0;
            default: ;
        endcase
    endtask

    // list due slots in slot order, last one flagged
    task automatic queue_due(input logic [7:0] due);
        int listed;
        listed = 0;
        for (int k = 0; k < TASKS; k++)
            if (due[k]) begin
                due_fifo.push_back('{slot: k[2:0], last: (due >> (k + 1)) == 8'd0});
                listed++;
            end
        if (listed > widest_tick) widest_tick = listed;
    endtask

    // present one word, hold until taken; tvalid stays high for a back-to-back word
    task automatic send_word(input logic [2:0] req, input logic [2:0] idx,
                             input logic [15:0] per, input logic typed,
                             input logic [7:0] typed_mask);
        logic [7:0] due;
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {5'b0, per, idx};
        do @(posedge aclk); while (!s_tready);
        apply_request(req, idx, per, due);
        if (typed) due = typed_mask;
        queue_due(due);
        words_sent++;
        if (req == ptd_pkg::REQ_TICK) ticks_sent++;
    endtask

    task automatic random_word();
        int pick;
        logic [2:0] req;
        logic [15:0] per;
        pick = $urandom_range(99);
        per  = 16'($urandom);
        if (pick < 48)      req = ptd_pkg::REQ_TICK;
        else if (pick < 68) req = ptd_pkg::REQ_CREATE;
        else if (pick < 76) req = ptd_pkg::REQ_SUSPEND;
        else if (pick < 84) req = ptd_pkg::REQ_RESUME;
        else if (pick < 95) req = ptd_pkg::REQ_DELETE;
        else                req = 3'($urandom_range(7, 5));
        // mostly short periods so ticks keep firing
        if (req == ptd_pkg::REQ_CREATE) begin
            pick = $urandom_range(99);
            if (pick < 60)      per = 16'($urandom_range(6, 1));
            else if (pick < 75) per = 16'($urandom_range(40, 7));
            else if (pick < 85) per = 16'd0;
        end
        send_word(req, 3'($urandom_range(7)), per, 1'b0, '0);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_fifo.size() != 0) @(posedge aclk);
    endtask

    // receiver stall pattern
    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= sink_stall_pct);

    // check each result word against the oldest listed due slot
    always @(posedge aclk) begin : result_check
        due_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_fifo.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result word: slot %0d last %0b",
                             m_tdata[2:0], m_tlast);
            end else begin
                want = due_fifo.pop_front();
                dues_checked++;
                if (m_tdata[2:0] !== want.slot || m_tlast !== want.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch at tick %0d: expected slot %0d last %0b, ",
                                  "got slot %0d last %0b"},
                                 tick_total, want.slot, want.last, m_tdata[2:0], m_tlast);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        tick_total = '0;
        slot_busy  = '0;
        slot_held  = '0;
        for (int k = 0; k < TASKS; k++) slot_per[k] = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_plan[r])
            send_word(directed_plan[r].req, directed_plan[r].idx, directed_plan[r].per,
                      directed_plan[r].typed, directed_plan[r].due_mask);

        // random phases: none, sender idle, receiver stall, both; drain between phases
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            src_idle_pct   = (ph == 1) ? 58 : (ph == 3) ? 22 : 0;
            sink_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 22 : 0;
            repeat (RAND_WORDS) random_word();
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (due_fifo.size() != 0) fail_count++;

        $display("sent %0d words (%0d ticks) across four idling phases; checked %0d due slots,",
                 words_sent, ticks_sent, dues_checked);
        $display("widest tick listed %0d slots; %0d failures", widest_tick, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/ptd_pkg.sv
hw/rtl/ptd_ctrl.sv
hw/rtl/ptd_datapath.sv
hw/rtl/periodic_task_dispatcher_core.sv
sim/testbench.sv
